[rtl/core/sms_pkg.sv]
package sms_pkg;

   localparam int ROW_W    = 8;
   localparam int COL_W    = 8;
   localparam int KEY_W    = ROW_W + COL_W;
   localparam int DATA_W   = 64;
   localparam int DIM_W    = 9;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef struct packed {
      logic     cmp_en;
      logic     ins_en;
      logic     upd_en;
      key_type  req_key;
      data_type req_value;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

endpackage

[rtl/core/sms_req_if.sv]
interface sms_req_if import sms_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [ROW_W-1:0]     row;
   logic [COL_W-1:0]     col;
   logic [DATA_W-1:0]    write_data;

   modport source (output valid, mode, row, col, write_data, input ready);
   modport sink   (input valid, mode, row, col, write_data, output ready);
endinterface

[rtl/core/sms_rsp_if.sv]
interface sms_rsp_if import sms_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    read_data;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, read_data, status, input ready);
   modport sink   (input valid, read_data, status, output ready);
endinterface

[rtl/core/sms_csr_if.sv]
interface sms_csr_if import sms_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/sms_cell.sv]
module sms_cell import sms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          entry_valid,
   input  logic          left_lt,
   input  key_type       left_key,
   input  data_type      left_value,
   output logic          lt,
   output logic          eq,
   output key_type       key,
   output data_type      value
);

   logic     lt_ff, lt_in;
   logic     eq_ff, eq_in;
   key_type  key_ff, key_in;
   data_type value_ff, value_in;

   always_comb begin
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.cmp_en) begin
         lt_in = entry_valid && (key_ff < ctrl.req_key);
         eq_in = entry_valid && (key_ff == ctrl.req_key);
      end
      if (ctrl.ins_en && !lt_ff) begin
         // take the new entry at the sorted slot, else shift up from the left
         if (left_lt) begin
            key_in   = ctrl.req_key;
            value_in = ctrl.req_value;
         end else begin
            key_in   = left_key;
            value_in = left_value;
         end
      end else if (ctrl.upd_en && eq_ff) begin
         value_in = ctrl.req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule

[rtl/core/sparse_matrix_coordinate_store_core.sv]
// A request beat is accepted only in the idle state; the core then compares it
// in every cell, then updates or shifts the cell row for a write and registers
// the result, waiting while an earlier result is still held by the receiver.
// Reset: synchronous; the table reads as empty and row_count and col_count
// return to 256.
module sparse_matrix_coordinate_store_core import sms_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic     clock,
   input  logic     reset,
   sms_req_if.sink  req_if,
   sms_rsp_if.source rsp_if,
   sms_csr_if.sink  csr_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [DIM_W-1:0]  col_count_ff, col_count_in;

   logic              mode_ff;
   key_type           key_ff;
   data_type          data_ff;
   logic              skip_ff;
   logic              range_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   data_type          read_data_ff, read_data_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   cell_ctrl_type     ctrl;
   logic [CAPACITY-1:0] cell_lt;
   logic [CAPACITY-1:0] cell_eq;
   key_type           cell_key [CAPACITY];
   data_type          cell_value [CAPACITY];

   logic              req_fire;
   logic              exec_go;
   logic              hit;
   logic              full;
   data_type          hit_value;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign exec_go      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   assign hit  = |cell_eq;
   assign full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_value = hit_value | (cell_eq[i] ? cell_value[i] : '0);
      end
   end

   always_comb begin
      ctrl.cmp_en    = (state_ff == ST_CMP);
      ctrl.ins_en    = 1'b0;
      ctrl.upd_en    = 1'b0;
      ctrl.req_key   = key_ff;
      ctrl.req_value = data_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      read_data_in   = read_data_ff;
      status_in      = status_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         read_data_in = '0;
         status_in    = STATUS_OK;
         priority if (skip_ff) begin
            status_in = STATUS_OK;
         end else if (range_ff) begin
            status_in = STATUS_RANGE;
         end else if (mode_ff == MODE_READ) begin
            read_data_in = hit_value;
         end else if (hit) begin
            ctrl.upd_en = 1'b1;
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            ctrl.ins_en = 1'b1;
            count_in    = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_CMP;
         ST_CMP:  state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_if.valid) begin
         if (csr_if.index == CSR_ROW_COUNT) row_count_in = csr_if.data;
         if (csr_if.index == CSR_COL_COUNT) col_count_in = csr_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         row_count_ff <= DIM_RESET;
         col_count_ff <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      read_data_ff <= read_data_in;
      status_ff    <= status_in;
      if (req_fire) begin
         mode_ff  <= req_if.mode;
         key_ff   <= {req_if.row, req_if.col};
         data_ff  <= req_if.write_data;
         skip_ff  <= (req_if.mode == MODE_WRITE) && (req_if.write_data[DATA_W-2:0] == '0);
         range_ff <= ({1'b0, req_if.row} >= row_count_ff) ||
                     ({1'b0, req_if.col} >= col_count_ff);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic     left_lt;
      key_type  left_key;
      data_type left_value;
      logic     entry_valid;

      assign entry_valid = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_key   = '0;
         assign left_value = '0;
      end else begin : g_body
         assign left_lt    = cell_lt[i-1];
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
      end

      sms_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .entry_valid (entry_valid),
         .left_lt     (left_lt),
         .left_key    (left_key),
         .left_value  (left_value),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i]),
         .key         (cell_key[i]),
         .value       (cell_value[i])
      );
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = read_data_ff;
   assign rsp_if.status    = status_ff;

endmodule

[sim/coordinate_store_checker.sv]
module coordinate_store_checker import sms_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic clock,
   input  logic reset,
   sms_req_if   req_mon,
   sms_rsp_if   rsp_mon,
   sms_csr_if   csr_mon,
   output int   failures,
   output int   outstanding,
   output int   read_hits,
   output int   range_errors,
   output int   full_rejects,
   output int   inserts
);

   typedef struct packed {
      data_type              read_data;
      logic [STATUS_W-1:0]   status;
   } access_result_type;

   logic [DIM_W-1:0]  row_limit;
   logic [DIM_W-1:0]  col_limit;
   key_type           cell_key [CAPACITY];
   data_type          cell_val [CAPACITY];
   int                cell_total;
   access_result_type expected_results [$];

   function automatic access_result_type apply_access(
      input logic             mode,
      input logic [ROW_W-1:0] r,
      input logic [COL_W-1:0] c,
      input data_type         wdata
   );
      access_result_type res;
      key_type           key;
      int                pos;
      logic              hit;
      res.read_data = '0;
      res.status    = STATUS_OK;
      key           = {r, c};
      if (mode == MODE_WRITE && wdata[DATA_W-2:0] == '0) return res;
      if ({1'b0, r} >= row_limit || {1'b0, c} >= col_limit) begin
         res.status = STATUS_RANGE;
         return res;
      end
      pos = 0;
      while (pos < cell_total && cell_key[pos] < key) pos++;
      hit = (pos < cell_total) && (cell_key[pos] == key);
      if (mode == MODE_READ) begin
         if (hit) res.read_data = cell_val[pos];
      end else if (hit) begin
         cell_val[pos] = wdata;
      end else if (cell_total >= CAPACITY) begin
         res.status = STATUS_FULL;
      end else begin
         for (int k = cell_total; k > pos; k--) begin
            cell_key[k] = cell_key[k-1];
            cell_val[k] = cell_val[k-1];
         end
         cell_key[pos] = key;
         cell_val[pos] = wdata;
         cell_total++;
         inserts++;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      access_result_type want;
      if (reset) begin
         expected_results.delete();
         cell_total   = 0;
         row_limit    = DIM_RESET;
         col_limit    = DIM_RESET;
         failures     = 0;
         read_hits    = 0;
         range_errors = 0;
         full_rejects = 0;
         inserts      = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_ROW_COUNT) row_limit = csr_mon.data;
            else if (csr_mon.index == CSR_COL_COUNT) col_limit = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready) begin
            want = apply_access(req_mon.mode, req_mon.row, req_mon.col, req_mon.write_data);
            expected_results.push_back(want);
            if (req_mon.mode == MODE_READ && want.read_data != '0) read_hits++;
            if (want.status == STATUS_RANGE) range_errors++;
            if (want.status == STATUS_FULL) full_rejects++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result beat: read_data %h status %0d",
                      rsp_mon.read_data, rsp_mon.status);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.read_data !== want.read_data) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         want.read_data, rsp_mon.read_data);
                  failures++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  failures++;
               end
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

[sim/sparse_matrix_coordinate_store_core_tb.sv]
module sparse_matrix_coordinate_store_core_tb import sms_pkg::*; ();

   localparam int CAPACITY    = 64;
   localparam int LONG_HOLD   = 80;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 35;
   localparam int FILL_PHASE  = 2;
   localparam int HOLD_PHASE  = 4;
   localparam int FILL_ITEMS  = 70;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam data_type ONE_POINT_ZERO = 64'h3FF0_0000_0000_0000;
   localparam data_type NEG_ZERO       = 64'h8000_0000_0000_0000;
   localparam data_type TINY_VALUE     = 64'h0000_0000_0000_0001;

   localparam logic [DIM_W-1:0] PHASE_ROWS [PHASES] =
      '{9'd256, 9'd1, 9'd255, 9'd0, 9'd511, 9'd256, 9'd4, 9'd128, 9'd256};
   localparam logic [DIM_W-1:0] PHASE_COLS [PHASES] =
      '{9'd256, 9'd1, 9'd255, 9'd256, 9'd511, 9'd0, 9'd6, 9'd3, 9'd256};

   logic clock;
   logic reset;

   sms_req_if req_if ();
   sms_rsp_if rsp_if ();
   sms_csr_if csr_if ();

   int failures;
   int outstanding;
   int read_hits;
   int range_errors;
   int full_rejects;
   int inserts;
   int accesses;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rsp;

   logic [DIM_W-1:0] rows_in_use;
   logic [DIM_W-1:0] cols_in_use;

   sparse_matrix_coordinate_store_core #(.CAPACITY(CAPACITY)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   coordinate_store_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .csr_mon      (csr_if),
      .failures     (failures),
      .outstanding  (outstanding),
      .read_hits    (read_hits),
      .range_errors (range_errors),
      .full_rejects (full_rejects),
      .inserts      (inserts)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sparse_matrix_coordinate_store_core test failed");
      $finish;
   end

   initial begin : response_sink
      int held;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [ROW_W-1:0] pick_coord(input logic [DIM_W-1:0] limit);
      int sel;
      int bound;
      sel = $urandom_range(99);
      if (sel < 60) return ROW_W'($urandom_range(7));
      if (sel < 80) return ROW_W'($urandom_range(255));
      bound = int'(limit) - 1 + int'($urandom_range(2));
      if (bound < 0) bound = 0;
      if (bound > 255) bound = 255;
      return ROW_W'(bound);
   endfunction

   function automatic data_type pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) return '0;
      if (sel < 14) return NEG_ZERO;
      if (sel < 18) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic send_access(
      input logic             mode,
      input logic [ROW_W-1:0] r,
      input logic [COL_W-1:0] c,
      input data_type         wdata
   );
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.mode       <= mode;
      req_if.row        <= r;
      req_if.col        <= c;
      req_if.write_data <= wdata;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      accesses++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
      write_csr(CSR_ROW_COUNT, rows);
      write_csr(CSR_COL_COUNT, cols);
      write_csr(CSR_UNMAPPED, DIM_W'($urandom));
      csr_if.valid <= 1'b0;
      rows_in_use = rows;
      cols_in_use = cols;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      req_if.valid      <= 1'b0;
      req_if.mode       <= MODE_READ;
      req_if.row        <= '0;
      req_if.col        <= '0;
      req_if.write_data <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_ROW_COUNT;
      csr_if.data       <= DIM_RESET;
      reset             <= 1'b1;
      accesses       = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_rsp       = 1'b0;
      rows_in_use    = DIM_RESET;
      cols_in_use    = DIM_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_access(MODE_READ,  8'd0,   8'd0,   '0);
      send_access(MODE_WRITE, 8'd0,   8'd0,   ONE_POINT_ZERO);
      send_access(MODE_READ,  8'd0,   8'd0,   '0);
      send_access(MODE_WRITE, 8'd0,   8'd0,   '0);
      send_access(MODE_WRITE, 8'd0,   8'd0,   NEG_ZERO);
      send_access(MODE_READ,  8'd0,   8'd0,   '1);
      send_access(MODE_WRITE, 8'd255, 8'd255, '1);
      send_access(MODE_READ,  8'd255, 8'd255, '0);
      send_access(MODE_WRITE, 8'd0,   8'd255, {$urandom, $urandom} | TINY_VALUE);
      send_access(MODE_WRITE, 8'd255, 8'd0,   {$urandom, $urandom} | TINY_VALUE);
      send_access(MODE_WRITE, 8'd10,  8'd10,  {$urandom, $urandom} | TINY_VALUE);
      send_access(MODE_READ,  8'd10,  8'd10,  '0);
      send_access(MODE_WRITE, 8'd10,  8'd10,  ONE_POINT_ZERO | NEG_ZERO);
      send_access(MODE_READ,  8'd10,  8'd10,  '0);
      send_access(MODE_READ,  8'd10,  8'd11,  '0);
      send_access(MODE_WRITE, 8'd200, 8'd3,   {$urandom, $urandom} | TINY_VALUE);
      send_access(MODE_READ,  8'd255, 8'd0,   '0);
      send_access(MODE_READ,  8'd0,   8'd255, '0);
      send_access(MODE_WRITE, 8'd255, 8'd255, TINY_VALUE);
      send_access(MODE_READ,  8'd255, 8'd255, '0);
      send_access(MODE_READ,  8'd200, 8'd3,   '0);

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         set_dims(PHASE_ROWS[phase], PHASE_COLS[phase]);
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 47;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 47;
            end
            default: begin
               send_idle_pct  = 19;
               recv_stall_pct = 19;
            end
         endcase
         if (phase == FILL_PHASE) begin
            for (n = 0; n < FILL_ITEMS; n++)
               send_access(MODE_WRITE, ROW_W'(64 + n), COL_W'($urandom_range(254)),
                           {$urandom, $urandom} | TINY_VALUE);
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == HOLD_PHASE && n == 4) hold_rsp = 1'b1;
            send_access(1'($urandom_range(1)), pick_coord(rows_in_use),
                        pick_coord(cols_in_use), pick_value());
         end
      end
      drain();

      $display("Covered %0d accesses over %0d dimension settings plus reset values",
               accesses, PHASES);
      $display("  %0d read hits, %0d out-of-range, %0d full rejects, %0d inserts",
               read_hits, range_errors, full_rejects, inserts);
      if (failures == 0 && outstanding == 0) begin
         $display("sparse_matrix_coordinate_store_core test passed");
      end else begin
         $display("sparse_matrix_coordinate_store_core test failed");
      end
      $finish;
   end

endmodule
